// ===== design/socest_pkg.sv =====
// Shared types, constants and helpers for the cell state-of-charge estimator.
package socest_pkg;

  localparam int MAX_CELLS   = 4;
  localparam int FIELD_CELLS = 4;
  localparam int CELL_IDX_W  = $clog2(FIELD_CELLS);
  localparam int CELL_CNT_W  = 3;
  localparam logic [CELL_CNT_W-1:0] CELL_LIMIT =
    CELL_CNT_W'(MAX_CELLS < FIELD_CELLS ? MAX_CELLS : FIELD_CELLS);

  localparam int PCT_W = 14;
  localparam logic [15:0] FULL_HUNDREDTHS = 16'd10000;
  localparam logic [15:0] ZERO_SPAN_MV    = 16'd1000;

  // Restoring divider: 18 quotient bits cover the clamped Q.16 ratio and
  // the capacity scaling alike.
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_STEPS  = 18;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [DIV_STEPS-1:0] X_LIMIT = DIV_STEPS'(163840);
  localparam logic [DIV_STEPS-1:0] X_HALF  = DIV_STEPS'(32768);

  // 0.5 in Q.48, the constant term of the curve numerator
  localparam logic signed [55:0] NUM_BIAS = 56'sd1 <<< 47;

  // x625 is done as four x5 passes.
  localparam int SCALE_STEPS = 4;
  localparam int SCALE_CNT_W = $clog2(SCALE_STEPS);

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_RATED    = 3'd0,
    REG_EMPTY    = 3'd1,
    REG_CELLS    = 3'd2,
    REG_CAPACITY = 3'd3,
    REG_REST     = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SQ,
    S_CUBE,
    S_POLY,
    S_SCALE,
    S_STORE,
    S_CLAMP,
    S_REM_MUL,
    S_REM_GO,
    S_REM_WAIT,
    S_DONE
  } socest_state_t;

  typedef struct packed {
    logic [15:0]        cell_a_mv;
    logic [15:0]        cell_b_mv;
    logic [15:0]        cell_c_mv;
    logic [15:0]        cell_d_mv;
    logic signed [15:0] pack_current_ma;
    logic               samples_settled;
    logic               rearm;
  } item_t;

  typedef struct packed {
    logic [15:0] soc_a;
    logic [15:0] soc_b;
    logic [15:0] soc_c;
    logic [15:0] soc_d;
    logic [1:0]  lowest_cell;
    logic [15:0] remaining_capacity;
    logic        fresh;
    logic        latched;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic                 overflow;
    logic [DIV_STEPS-1:0] quotient;
  } div_rsp_t;

  function automatic logic [15:0] cell_mv(input item_t it, input logic [CELL_IDX_W-1:0] idx);
    logic [15:0] v;
    case (idx)
      2'd0:    v = it.cell_a_mv;
      2'd1:    v = it.cell_b_mv;
      2'd2:    v = it.cell_c_mv;
      default: v = it.cell_d_mv;
    endcase
    return v;
  endfunction

endpackage

// ===== design/socest_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module socest_div import socest_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIV_STEPS-1:0] quo;
  logic [DIV_CNT_W-1:0] steps;
  logic                 busy;
  logic                 done;
  logic                 overflow;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W+1:0] diff;
  logic [DIVISOR_W-1:0] upper;

  assign upper   = DIVISOR_W'(req.dividend[DIVIDEND_W-1:DIV_STEPS]);
  assign shifted = {rem, quo[DIV_STEPS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && steps == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Quotient bits shift in as dividend bits shift out.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= upper;
      quo      <= req.dividend[DIV_STEPS-1:0];
      divisor  <= req.divisor;
      overflow <= (upper >= req.divisor);
      steps    <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      steps <= steps - DIV_CNT_W'(1);
      if (!diff[DIVISOR_W+1]) begin
        rem <= diff[DIVISOR_W-1:0];
        quo <= {quo[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= shifted[DIVISOR_W-1:0];
        quo <= {quo[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.overflow = overflow;
  assign rsp.quotient = quo;

endmodule

// ===== design/cell_state_of_charge_estimator.sv =====
// Top level of the open-circuit-voltage cell state-of-charge estimator.
//
// Each item is taken only while the block is idle. An item that makes no estimate
// (latch closed, pack not resting, or samples not settled) goes straight to the done state
// and loads its result into the output register once that register is free, after which
// the block returns to idle. An estimate runs the fitted cells one after another through
// a shared 18-step restoring divider and one 36x19 multiplier, then clamps the weakest
// cell, scales the capacity through the same divider and loads the result. Most of an
// estimate's time is spent in the divider. A finished result waits in an output register
// while the next item may already be transferred in.
module cell_state_of_charge_estimator import socest_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration registers
  logic [15:0] rated_millivolts;
  logic [15:0] empty_millivolts;
  logic [2:0]  cells_in_use;
  logic [15:0] full_capacity;
  logic [14:0] rest_current_limit;

  // Block state
  socest_state_t state, state_next;
  logic [15:0]   soc_store [FIELD_CELLS];
  logic          estimate_taken;
  logic [1:0]    weakest_index;
  logic [15:0]   remaining_store;
  logic          fresh;

  // Working registers
  item_t                  cur_item;
  logic [CELL_IDX_W-1:0]  cell_idx;
  logic [CELL_CNT_W-1:0]  cell_total;
  logic [CELL_IDX_W-1:0]  low_idx;
  logic [15:0]            best;
  logic signed [18:0]     dval;
  logic signed [54:0]     prod;
  logic [60:0]            acc;
  logic                   num_neg;
  logic                   num_big;
  logic [SCALE_CNT_W-1:0] scale_cnt;
  logic [PCT_W-1:0]       pct;

  // Combinational
  logic                  item_take;
  logic [15:0]           cur_mag;
  logic                  go_est;
  logic [CELL_CNT_W-1:0] cells_active;
  logic [16:0]           span_diff;
  logic                  span_neg;
  logic [15:0]           span_div;
  logic [15:0]           head;
  logic [15:0]           cur_mv;
  logic [DIV_STEPS-1:0]  x_clamped;
  logic signed [35:0]    mul_a;
  logic signed [18:0]    mul_b;
  logic signed [54:0]    mul_p;
  logic signed [55:0]    prod_x;
  logic signed [55:0]    d_x;
  logic signed [55:0]    num_w;
  logic [15:0]           soc_val;
  logic [15:0]           low_soc;
  logic [15:0]           pct_w;
  logic                  last_cell;
  logic                  result_load;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  socest_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rated_millivolts   <= 16'd4200;
      empty_millivolts   <= 16'd3000;
      cells_in_use       <= 3'd4;
      full_capacity      <= 16'd0;
      rest_current_limit <= 15'd50;
    end else if (psel && penable && pwrite) begin
      case (cfg_reg_t'(paddr[4:2]))
        REG_RATED:    rated_millivolts   <= pwdata[15:0];
        REG_EMPTY:    empty_millivolts   <= pwdata[15:0];
        REG_CELLS:    cells_in_use       <= pwdata[2:0];
        REG_CAPACITY: full_capacity      <= pwdata[15:0];
        REG_REST:     rest_current_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[4:2]))
      REG_RATED:    prdata = APB_DATA_W'(rated_millivolts);
      REG_EMPTY:    prdata = APB_DATA_W'(empty_millivolts);
      REG_CELLS:    prdata = APB_DATA_W'(cells_in_use);
      REG_CAPACITY: prdata = APB_DATA_W'(full_capacity);
      REG_REST:     prdata = APB_DATA_W'(rest_current_limit);
      default:      prdata = '0;
    endcase
  end

  // ---------------- input decisions ----------------
  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;

  assign cur_mag      = item.pack_current_ma[15] ? (~item.pack_current_ma + 16'd1)
                                                 : item.pack_current_ma;
  assign go_est       = (!estimate_taken || item.rearm) && item.samples_settled &&
                        (cur_mag < {1'b0, rest_current_limit});
  assign cells_active = (cells_in_use > CELL_LIMIT) ? CELL_LIMIT : cells_in_use;

  // ---------------- cell arithmetic ----------------
  assign span_diff = {1'b0, rated_millivolts} - {1'b0, empty_millivolts};
  assign span_neg  = span_diff[16];
  assign span_div  = (span_diff == 17'd0) ? ZERO_SPAN_MV : span_diff[15:0];

  assign cur_mv = cell_mv(cur_item, cell_idx);
  assign head   = (cur_mv > empty_millivolts) ? (cur_mv - empty_millivolts) : 16'd0;

  assign x_clamped = (div_rsp.overflow || div_rsp.quotient > X_LIMIT) ? X_LIMIT
                                                                     : div_rsp.quotient;

  assign mul_p = mul_a * mul_b;

  assign prod_x = {prod[54], prod};
  assign d_x    = {{37{dval[18]}}, dval};
  assign num_w  = (prod_x <<< 1) + (d_x <<< 31) + NUM_BIAS;

  always_comb begin
    if (num_neg || span_neg) begin
      soc_val = 16'd0;
    end else if (num_big || acc[60]) begin
      soc_val = 16'hFFFF;
    end else begin
      soc_val = acc[59:44];
    end
  end

  assign low_soc   = soc_store[low_idx];
  assign pct_w     = (low_soc > FULL_HUNDREDTHS) ? FULL_HUNDREDTHS : low_soc;
  assign last_cell = ({1'b0, cell_idx} + CELL_CNT_W'(1)) == cell_total;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_take) begin
          if (!go_est) begin
            state_next = S_DONE;
          end else if (cells_active == '0) begin
            state_next = S_CLAMP;
          end else begin
            state_next = S_DIV_GO;
          end
        end
      end
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (div_rsp.done) state_next = S_SQ;
      S_SQ:       state_next = S_CUBE;
      S_CUBE:     state_next = S_POLY;
      S_POLY:     state_next = S_SCALE;
      S_SCALE:    if (scale_cnt == '0) state_next = S_STORE;
      S_STORE:    state_next = last_cell ? S_CLAMP : S_DIV_GO;
      S_CLAMP:    state_next = S_REM_MUL;
      S_REM_MUL:  state_next = S_REM_GO;
      S_REM_GO:   state_next = S_REM_WAIT;
      S_REM_WAIT: if (div_rsp.done) state_next = S_DONE;
      S_DONE:     if (!result_valid || !result_stall) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {head, 16'd0};
    div_req.divisor  = span_div;
    mul_a            = '0;
    mul_b            = '0;
    result_load      = 1'b0;
    case (state)
      S_DIV_GO: div_req.start = 1'b1;
      S_SQ: begin
        mul_a = {{17{dval[18]}}, dval};
        mul_b = dval;
      end
      S_CUBE: begin
        mul_a = prod[35:0];
        mul_b = dval;
      end
      S_REM_MUL: begin
        mul_a = {{(36-PCT_W){1'b0}}, pct};
        mul_b = {3'b000, full_capacity};
      end
      S_REM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[DIVIDEND_W-1:0];
        div_req.divisor  = FULL_HUNDREDTHS;
      end
      S_DONE: result_load = !result_valid || !result_stall;
      default: ;
    endcase
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate_taken  <= 1'b0;
      weakest_index   <= '0;
      remaining_store <= '0;
      fresh           <= 1'b0;
      for (int i = 0; i < FIELD_CELLS; i++) soc_store[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_take) begin
            fresh <= 1'b0;
            if (item.rearm) estimate_taken <= 1'b0;
          end
        end
        S_STORE: soc_store[cell_idx] <= soc_val;
        S_CLAMP: soc_store[low_idx]  <= pct_w;
        S_REM_WAIT: begin
          if (div_rsp.done) begin
            remaining_store <= div_rsp.quotient[15:0];
            weakest_index   <= low_idx;
            estimate_taken  <= 1'b1;
            fresh           <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item_take) begin
          cur_item   <= item;
          cell_idx   <= '0;
          cell_total <= cells_active;
          low_idx    <= '0;
          best       <= FULL_HUNDREDTHS;
        end
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          dval <= $signed({1'b0, x_clamped}) - $signed({1'b0, X_HALF});
        end
      end
      S_SQ:   prod <= mul_p;
      S_CUBE: prod <= mul_p;
      S_POLY: begin
        num_neg   <= num_w[55] || (num_w == '0);
        num_big   <= !num_w[55] && (num_w[54:51] != '0);
        acc       <= {10'd0, num_w[50:0]};
        scale_cnt <= SCALE_CNT_W'(SCALE_STEPS - 1);
      end
      S_SCALE: begin
        acc       <= (acc << 2) + acc;
        scale_cnt <= scale_cnt - SCALE_CNT_W'(1);
      end
      S_STORE: begin
        // keep the first cell that is strictly lowest
        if (soc_val < best) begin
          best    <= soc_val;
          low_idx <= cell_idx;
        end
        cell_idx <= cell_idx + CELL_IDX_W'(1);
      end
      S_CLAMP:   pct  <= pct_w[PCT_W-1:0];
      S_REM_MUL: prod <= mul_p;
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.soc_a              <= soc_store[0];
      result.soc_b              <= soc_store[1];
      result.soc_c              <= soc_store[2];
      result.soc_d              <= soc_store[3];
      result.lowest_cell        <= weakest_index;
      result.remaining_capacity <= remaining_store;
      result.fresh              <= fresh;
      result.latched            <= estimate_taken;
    end
  end

endmodule
